// ===== hdl/gwwb_pkg.sv =====
// Shared types and constants for the greedy word-wrap break finder.
package gwwb_pkg;

  // Fixed field widths of the input and result requests.
  localparam int unsigned CODE_W   = 21;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned OUT_OFF_W = 16;
  localparam int unsigned REASON_W = 2;

  // Character codes that get special treatment.
  localparam logic [CODE_W-1:0] CP_NUL      = 21'h000000;
  localparam logic [CODE_W-1:0] CP_TAB      = 21'h000009;
  localparam logic [CODE_W-1:0] CP_NEWLINE  = 21'h00000A;
  localparam logic [CODE_W-1:0] CP_CR       = 21'h00000D;
  localparam logic [CODE_W-1:0] CP_SPACE    = 21'h000020;
  localparam logic [CODE_W-1:0] CP_IDEO_SP  = 21'h003000;
  localparam logic [CODE_W-1:0] CP_QUOTE    = 21'h000022;
  localparam logic [CODE_W-1:0] CP_BANG     = 21'h000021;
  localparam logic [CODE_W-1:0] CP_COMMA    = 21'h00002C;
  localparam logic [CODE_W-1:0] CP_PERIOD   = 21'h00002E;
  localparam logic [CODE_W-1:0] CP_SEMI     = 21'h00003B;
  localparam logic [CODE_W-1:0] CP_QUESTION = 21'h00003F;

  // Why a line ended.
  localparam logic [REASON_W-1:0] REASON_END_OF_TEXT = 2'd0;
  localparam logic [REASON_W-1:0] REASON_WRAPPED     = 2'd1;
  localparam logic [REASON_W-1:0] REASON_NUL         = 2'd2;

  // Character class decided by the front end.
  typedef enum logic [2:0] {
    KIND_NUL     = 3'd0,
    KIND_NEWLINE = 3'd1,
    KIND_CR      = 3'd2,
    KIND_BLANK   = 3'd3,
    KIND_MARK    = 3'd4,
    KIND_CHAR    = 3'd5
  } kind_t;

  // One classified character as it waits for the back end.
  typedef struct packed {
    kind_t               kind;
    logic [LEN_W-1:0]    len;
    logic [WIDTH_W-1:0]  width;
    logic [WIDTH_W-1:0]  limit;
    logic                last;
  } item_t;

  // One line break result.
  typedef struct packed {
    logic [OUT_OFF_W-1:0] offset;
    logic [REASON_W-1:0]  reason;
  } result_t;

  // Status of a queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/gwwb_queue.sv =====
// Small first-in first-out queue of registers with a combinational head.
module gwwb_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                rd_en,
  output logic [WIDTH-1:0]    rd_data,
  output gwwb_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/gwwb_front.sv =====
// Front end: accepts characters and sorts them into classes for the back end.
module gwwb_front (
  input  logic                                push,
  input  logic                                q_full,
  input  logic [gwwb_pkg::CODE_W-1:0]         code_point,
  input  logic [gwwb_pkg::LEN_W-1:0]          byte_length,
  input  logic [gwwb_pkg::WIDTH_W-1:0]        adv_width,
  input  logic [gwwb_pkg::WIDTH_W-1:0]        wrap_limit,
  input  logic                                last_char,
  output logic                                q_wr,
  output gwwb_pkg::item_t                     item
);

  logic is_blank;
  logic is_mark;

  assign q_wr = push && !q_full;

  assign is_blank = (code_point == gwwb_pkg::CP_SPACE) ||
                    (code_point == gwwb_pkg::CP_TAB) ||
                    (code_point == gwwb_pkg::CP_IDEO_SP);

  assign is_mark = (code_point == gwwb_pkg::CP_PERIOD) ||
                   (code_point == gwwb_pkg::CP_COMMA) ||
                   (code_point == gwwb_pkg::CP_SEMI) ||
                   (code_point == gwwb_pkg::CP_BANG) ||
                   (code_point == gwwb_pkg::CP_QUESTION) ||
                   (code_point == gwwb_pkg::CP_QUOTE);

  always_comb begin
    if (code_point == gwwb_pkg::CP_NUL) begin
      item.kind = gwwb_pkg::KIND_NUL;
    end else if (code_point == gwwb_pkg::CP_NEWLINE) begin
      item.kind = gwwb_pkg::KIND_NEWLINE;
    end else if (code_point == gwwb_pkg::CP_CR) begin
      item.kind = gwwb_pkg::KIND_CR;
    end else if (is_blank) begin
      item.kind = gwwb_pkg::KIND_BLANK;
    end else if (is_mark) begin
      item.kind = gwwb_pkg::KIND_MARK;
    end else begin
      item.kind = gwwb_pkg::KIND_CHAR;
    end
    // A zero length still moves the position by one byte.
    item.len   = (byte_length == '0) ? gwwb_pkg::LEN_W'(1) : byte_length;
    item.width = adv_width;
    item.limit = wrap_limit;
    item.last  = last_char;
  end

endmodule

// ===== hdl/gwwb_back.sv =====
// Back end: keeps the width sums and positions and decides where lines break.
module gwwb_back #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned ACCUM_BITS  = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  gwwb_pkg::item_t   item,
  output logic              emit,
  output gwwb_pkg::result_t result
);

  logic [ACCUM_BITS-1:0]  line_r, line_nxt;
  logic [ACCUM_BITS-1:0]  word_r, word_nxt;
  logic [ACCUM_BITS-1:0]  blank_r, blank_nxt;
  logic [OFFSET_BITS-1:0] word_stop_r, word_stop_nxt;
  logic [OFFSET_BITS-1:0] prior_end_r, prior_end_nxt;
  logic                   prior_seen_r, prior_seen_nxt;
  logic                   in_word_r, in_word_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   finished_r, finished_nxt;
  logic [gwwb_pkg::WIDTH_W-1:0] limit_r, limit_nxt;

  logic [OFFSET_BITS:0]   pos_sum;
  logic [OFFSET_BITS-1:0] here, next_pos, off;
  logic [ACCUM_BITS-1:0]  char_w, word_added;
  logic [ACCUM_BITS:0]    fit_sum;
  logic [ACCUM_BITS:0]    limit_ext;
  logic                   check;
  logic                   clear_all;
  logic [gwwb_pkg::REASON_W-1:0] reason;

  function automatic logic [ACCUM_BITS-1:0] sat_add(input logic [ACCUM_BITS-1:0] a,
                                                    input logic [ACCUM_BITS-1:0] b);
    logic [ACCUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACCUM_BITS] ? '1 : s[ACCUM_BITS-1:0];
  endfunction

  assign here     = pos_r;
  assign pos_sum  = {1'b0, pos_r} + (OFFSET_BITS + 1)'(item.len);
  assign next_pos = pos_sum[OFFSET_BITS] ? '1 : pos_sum[OFFSET_BITS-1:0];
  assign char_w   = ACCUM_BITS'(item.width);
  assign word_added = sat_add(word_r, char_w);

  always_comb begin
    line_nxt       = line_r;
    word_nxt       = word_r;
    blank_nxt      = blank_r;
    word_stop_nxt  = word_stop_r;
    prior_end_nxt  = prior_end_r;
    prior_seen_nxt = prior_seen_r;
    in_word_nxt    = in_word_r;
    pos_nxt        = pos_r;
    finished_nxt   = finished_r;
    limit_nxt      = limit_r;
    emit           = 1'b0;
    off            = '0;
    reason         = gwwb_pkg::REASON_END_OF_TEXT;
    check          = 1'b0;
    clear_all      = 1'b0;
    fit_sum        = '0;
    limit_ext      = '0;

    if (finished_r) begin
      clear_all = item.last;
    end else begin
      // The first character of a run carries the wrap limit.
      if (pos_r == '0) begin
        limit_nxt = item.limit;
      end
      case (item.kind)
        gwwb_pkg::KIND_NUL: begin
          emit   = 1'b1;
          off    = here;
          reason = gwwb_pkg::REASON_NUL;
        end
        gwwb_pkg::KIND_NEWLINE: begin
          line_nxt    = '0;
          word_nxt    = '0;
          blank_nxt   = '0;
          in_word_nxt = 1'b1;
        end
        gwwb_pkg::KIND_CR: begin
        end
        gwwb_pkg::KIND_BLANK: begin
          check = 1'b1;
          if (in_word_r) begin
            // A blank after a word closes the word and commits the earlier blanks.
            line_nxt      = sat_add(line_r, blank_r);
            word_stop_nxt = here;
            blank_nxt     = sat_add('0, char_w);
          end else begin
            blank_nxt = sat_add(blank_r, char_w);
          end
          in_word_nxt = 1'b0;
        end
        gwwb_pkg::KIND_MARK, gwwb_pkg::KIND_CHAR: begin
          check = 1'b1;
          if (in_word_r) begin
            word_nxt      = word_added;
            word_stop_nxt = next_pos;
          end else begin
            // A new word starts: the previous word and its blanks join the line.
            prior_end_nxt  = word_stop_r;
            prior_seen_nxt = 1'b1;
            line_nxt       = sat_add(line_r, sat_add(word_added, blank_r));
            word_nxt       = '0;
            blank_nxt      = '0;
          end
          in_word_nxt = (item.kind == gwwb_pkg::KIND_CHAR);
        end
        default: begin
        end
      endcase

      if (check) begin
        fit_sum   = {1'b0, line_nxt} + {1'b0, word_nxt};
        limit_ext = (ACCUM_BITS + 1)'(limit_nxt);
        if (fit_sum > limit_ext) begin
          emit   = 1'b1;
          reason = gwwb_pkg::REASON_WRAPPED;
          off    = here;
          // A word narrower than the limit goes whole to the next line.
          if ({1'b0, word_nxt} < limit_ext) begin
            off = prior_seen_nxt ? prior_end_nxt : word_stop_nxt;
          end
        end
      end

      pos_nxt = next_pos;
      if (!emit && item.last) begin
        emit   = 1'b1;
        off    = next_pos;
        reason = gwwb_pkg::REASON_END_OF_TEXT;
      end
      if (emit) begin
        if (item.last) begin
          clear_all = 1'b1;
        end else begin
          finished_nxt = 1'b1;
        end
      end
    end

    result.offset = gwwb_pkg::OUT_OFF_W'(off);
    result.reason = reason;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && clear_all)) begin
      line_r       <= '0;
      word_r       <= '0;
      blank_r      <= '0;
      word_stop_r  <= '0;
      prior_end_r  <= '0;
      prior_seen_r <= 1'b0;
      in_word_r    <= 1'b1;
      pos_r        <= '0;
      finished_r   <= 1'b0;
      limit_r      <= '0;
    end else if (go) begin
      line_r       <= line_nxt;
      word_r       <= word_nxt;
      blank_r      <= blank_nxt;
      word_stop_r  <= word_stop_nxt;
      prior_end_r  <= prior_end_nxt;
      prior_seen_r <= prior_seen_nxt;
      in_word_r    <= in_word_nxt;
      pos_r        <= pos_nxt;
      finished_r   <= finished_nxt;
      limit_r      <= limit_nxt;
    end
  end

endmodule

// ===== hdl/greedy_word_wrap_break.sv =====
// Top level of the greedy word-wrap break finder.
//
// Usage: decoded characters of one text run enter as requests on the input
// queue interface (push/full). Each request carries the code point, its UTF-8
// byte length, its advance width and the wrap limit (taken from the first
// character of a run), plus a flag on the last character. Break results leave
// through the result queue interface (empty/pop): while empty is low the
// oldest result stands on out_break_offset and out_end_reason, and pop takes it.
// At most one result comes from each character.
// The character queue registers each accepted character; the break logic then
// passes it on, and any result it causes is registered in the result queue,
// where it becomes visible. The back end takes one character per cycle while
// the result queue has room, and updates the width sums as it takes each one.
// Both queues hold two requests.
// When the receiver stalls, the result queue fills, the back end stops
// draining the character queue, and full rises once that queue is full too;
// nothing is lost. A synchronous reset (rst_n low) empties both queues and
// returns all sums and positions to the start of a new run.
module greedy_word_wrap_break #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned ACCUM_BITS  = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [gwwb_pkg::CODE_W-1:0]          in_code_point,
  input  logic [gwwb_pkg::LEN_W-1:0]           in_byte_length,
  input  logic [gwwb_pkg::WIDTH_W-1:0]         in_adv_width,
  input  logic [gwwb_pkg::WIDTH_W-1:0]         in_wrap_limit,
  input  logic                                 in_last_char,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [gwwb_pkg::OUT_OFF_W-1:0]       out_break_offset,
  output logic [gwwb_pkg::REASON_W-1:0]        out_end_reason
);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ITEM_W      = $bits(gwwb_pkg::item_t);
  localparam int unsigned RESULT_W    = $bits(gwwb_pkg::result_t);

  gwwb_pkg::item_t     front_item;
  gwwb_pkg::item_t     head_item;
  gwwb_pkg::result_t   back_result;
  gwwb_pkg::result_t   out_result;
  gwwb_pkg::q_status_t item_q;
  gwwb_pkg::q_status_t result_q;
  logic                item_wr;
  logic                back_go;
  logic                back_emit;

  gwwb_front u_front (
    .push        (push),
    .q_full      (item_q.full),
    .code_point  (in_code_point),
    .byte_length (in_byte_length),
    .adv_width   (in_adv_width),
    .wrap_limit  (in_wrap_limit),
    .last_char   (in_last_char),
    .q_wr        (item_wr),
    .item        (front_item)
  );

  gwwb_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (item_wr),
    .wr_data (front_item),
    .rd_en   (back_go),
    .rd_data (head_item),
    .status  (item_q)
  );

  // The back end takes a character only when any result it makes has room.
  assign back_go = !item_q.empty && !result_q.full;

  gwwb_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .ACCUM_BITS  (ACCUM_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (back_go),
    .item   (head_item),
    .emit   (back_emit),
    .result (back_result)
  );

  gwwb_queue #(
    .WIDTH (RESULT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_go && back_emit),
    .wr_data (back_result),
    .rd_en   (pop),
    .rd_data (out_result),
    .status  (result_q)
  );

  assign full             = item_q.full;
  assign empty            = result_q.empty;
  assign out_break_offset = out_result.offset;
  assign out_end_reason   = out_result.reason;

endmodule
